// ===== rtl/core/sorted_key_table_top_defines.svh =====
// Assertion macros for the sorted key table.
// Used by sorted_key_table_top; expects clk_i and rst_ni in scope.
`ifndef SORTED_KEY_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_TABLE_TOP_DEFINES_SVH

// check a condition at every clock edge outside reset
`define SKT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/skt_pkg.sv =====
// Types and constants for the sorted key table.
// No dependencies.
package skt_pkg;

  localparam int Depth    = 32;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW     = $clog2(Depth + 1);
  localparam int KeyW     = 32;
  localparam int PayW     = 64;
  localparam int CountW   = 6;
  localparam int InDataW  = 96;
  localparam int OutDataW = 104;

  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_HEAD,
    ST_DEL_RD,
    ST_DEL_CMP,
    ST_RD_RD,
    ST_RD_EMIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [PayW-1:0]        payload;
  } entry_t;

endpackage

// ===== rtl/core/sorted_key_table_top.sv =====
// Insert shifts entries up from the tail to open the new key's place (empty table: written
// at once; full: FULL status). Delete visits every entry, moving those past the match down.
// Read-all gives one item per entry, holding while the output is full. Each entry visit is
// a read state then a compare/write state. The next command is accepted once the previous
// one has handed its last item to the output register. Reset empties the count; table
// memory is not cleared. Holds the FSM, table memory and output register; uses skt_pkg.
`include "sorted_key_table_top_defines.svh"

module sorted_key_table_top
  import skt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // key[31:0], payload[95:32]
  input  logic [1:0]          s_axis_tuser,   // command[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // out_key[31:0], out_payload[95:32],
                                              // entry_count[101:96], zero[103:102]
  output logic [1:0]          m_axis_tuser,   // status[1:0]
  output logic                m_axis_tlast    // last
);

  state_e            state_q, state_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic              found_q, found_d;
  status_e           st_q, st_d;
  logic [KeyW-1:0]   key_q;
  logic [PayW-1:0]   pay_q;

  entry_t            mem_q [Depth];
  entry_t            rd_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            new_entry;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [KeyW-1:0]   out_key_q;
  logic [PayW-1:0]   out_pay_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_last_q;

  logic              in_acc, slot_free, load, shift_c, match_c, is_last_c;
  logic              res_last;
  status_e           res_status;
  entry_t            res_entry;
  cmd_e              cmd;

  assign cmd       = cmd_e'(s_axis_tuser);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign new_entry = '{key: key_q, payload: pay_q};
  assign shift_c   = (idx_q == '0) ? ($signed(key_q) < rd_q.key)
                                   : (rd_q.key >= $signed(key_q));
  assign match_c   = (rd_q.key == $signed(key_q));
  assign is_last_c = ((CntW'(idx_q) + 1'b1) == fill_q);
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_INSERT: state_d = (fill_q == '0 || fill_q >= DepthCnt) ? ST_EMIT : ST_INS_RD;
            CMD_DELETE: state_d = (fill_q == '0) ? ST_EMIT : ST_DEL_RD;
            CMD_CLEAR:  state_d = ST_EMIT;
            CMD_READ:   state_d = (fill_q == '0) ? ST_EMIT : ST_RD_RD;
            default:    state_d = ST_EMIT;
          endcase
        end
      end
      ST_INS_RD:   state_d = ST_INS_CMP;
      ST_INS_CMP: begin
        if (!shift_c) state_d = ST_EMIT;
        else if (idx_q == '0) state_d = ST_INS_HEAD;
        else state_d = ST_INS_RD;
      end
      ST_INS_HEAD: state_d = ST_EMIT;
      ST_DEL_RD:   state_d = ST_DEL_CMP;
      ST_DEL_CMP:  state_d = is_last_c ? ST_EMIT : ST_DEL_RD;
      ST_RD_RD:    state_d = ST_RD_EMIT;
      ST_RD_EMIT: begin
        if (slot_free) state_d = is_last_c ? ST_IDLE : ST_RD_RD;
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_d     = fill_q;
    idx_d      = idx_q;
    found_d    = found_q;
    st_d       = st_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    wr_addr    = idx_q;
    wr_data    = new_entry;
    load       = 1'b0;
    res_status = st_q;
    res_entry  = '0;
    res_last   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          st_d    = STAT_OK;
          found_d = 1'b0;
          idx_d   = '0;
          case (cmd)
            CMD_INSERT: begin
              if (fill_q >= DepthCnt) begin
                st_d = STAT_FULL;
              end else if (fill_q == '0) begin
                mem_we  = 1'b1;
                wr_addr = '0;
                wr_data = '{key: s_axis_tdata[KeyW-1:0],
                            payload: s_axis_tdata[KeyW +: PayW]};
                fill_d  = fill_q + 1'b1;
              end else begin
                idx_d = AddrW'(fill_q - 1'b1);
              end
            end
            CMD_DELETE: begin
              if (fill_q == '0) st_d = STAT_NOTFOUND;
            end
            CMD_CLEAR: begin
              fill_d = '0;
            end
            CMD_READ: begin
              if (fill_q == '0) st_d = STAT_EMPTY;
            end
            default: st_d = STAT_OK;
          endcase
        end
      end
      ST_INS_RD: mem_re = 1'b1;
      ST_INS_CMP: begin
        mem_we  = 1'b1;
        wr_addr = idx_q + 1'b1;
        if (shift_c) begin
          wr_data = rd_q;
          if (idx_q != '0) idx_d = idx_q - 1'b1;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      ST_INS_HEAD: begin
        mem_we  = 1'b1;
        wr_addr = '0;
        fill_d  = fill_q + 1'b1;
      end
      ST_DEL_RD: mem_re = 1'b1;
      ST_DEL_CMP: begin
        if (found_q) begin
          mem_we  = 1'b1;
          wr_addr = idx_q - 1'b1;
          wr_data = rd_q;
        end
        found_d = found_q || match_c;
        if (is_last_c) begin
          if (found_d) fill_d = fill_q - 1'b1;
          else st_d = STAT_NOTFOUND;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RD_RD: mem_re = 1'b1;
      ST_RD_EMIT: begin
        res_status = STAT_OK;
        res_entry  = rd_q;
        res_last   = is_last_c;
        load       = slot_free;
        if (slot_free && !is_last_c) idx_d = idx_q + 1'b1;
      end
      ST_EMIT: load = slot_free;
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      st_q        <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      st_q    <= st_d;
      if (load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= s_axis_tdata[KeyW-1:0];
      pay_q <= s_axis_tdata[KeyW +: PayW];
    end
    if (load) begin
      out_status_q <= res_status;
      out_key_q    <= res_entry.key;
      out_pay_q    <= res_entry.payload;
      out_cnt_q    <= CountW'(fill_q);
      out_last_q   <= res_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_data;
    if (mem_re) rd_q <= mem_q[idx_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OutDataW - KeyW - PayW - CountW){1'b0}},
                          out_cnt_q, out_pay_q, out_key_q};

  `SKT_ASSERT(a_fill_bound, fill_q <= DepthCnt, "entry count beyond table depth")
  `SKT_ASSERT_IMP(a_load_slot, load, !out_valid_q || m_axis_tready, "result overwritten")
  `SKT_ASSERT_IMP(a_port_excl, mem_we, !mem_re, "table read and write in one cycle")
  `SKT_ASSERT_IMP(a_fill_step, fill_q != $past(fill_q),
    fill_q == $past(fill_q) + 1'b1 || fill_q == $past(fill_q) - 1'b1 || fill_q == '0,
    "entry count jumped")

endmodule

// ===== tb/sorted_key_table_top_tb.sv =====
// Self-checking testbench for sorted_key_table_top: insert, delete, clear and read-all commands.
// A shadow copy of the sorted table predicts every output item; uses skt_pkg and the RTL only.
module sorted_key_table_top_tb;
  import skt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;
  localparam int TailCycles    = 80;
  localparam int RandomItems   = 210;
  localparam int QuietItems    = 30;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] key;
    logic [63:0] payload;
    bit          drain;
  } table_cmd_t;

  typedef struct {
    status_e            status;
    logic signed [31:0] key;
    logic [63:0]        payload;
    logic [5:0]         fill;
    logic               is_last;
  } table_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // key[31:0], payload[95:32]
  logic [1:0]          s_axis_tuser = CMD_INSERT;   // command[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;   // out_key[31:0], out_payload[95:32],
                                       // entry_count[101:96], zero[103:102]
  logic [1:0]          m_axis_tuser;   // status[1:0]
  logic                m_axis_tlast;

  table_cmd_t    cmd_q[$];
  table_result_t due_results[$];
  entry_t        shadow_rows[$];
  table_cmd_t    cur_cmd;
  bit            presenting = 1'b0;
  bit            tail_phase = 1'b0;
  int            in_gap = 0;
  int            out_stall = 0;
  int            idle_cycles = 0;
  int            n_errors = 0;

  sorted_key_table_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
    n_errors++;
  endtask

  function automatic void push_result(status_e status, logic [31:0] key,
                                      logic [63:0] payload, logic is_last);
    table_result_t r;
    r.status  = status;
    r.key     = key;
    r.payload = payload;
    r.fill    = 6'(shadow_rows.size());
    r.is_last = is_last;
    due_results.push_back(r);
  endfunction

  function automatic void apply_table_cmd(table_cmd_t c);
    int     n;
    int     pos;
    entry_t row;
    n = shadow_rows.size();
    case (c.cmd)
      CMD_INSERT: begin
        if (n >= Depth) begin
          push_result(STAT_FULL, '0, '0, 1'b1);
        end else begin
          pos = n;
          if (n == 0 || $signed(c.key) < $signed(shadow_rows[0].key)) begin
            pos = 0;
          end else begin
            for (int i = 1; i < n && pos == n; i++) begin
              if ($signed(shadow_rows[i].key) >= $signed(c.key)) pos = i;
            end
          end
          row.key     = c.key;
          row.payload = c.payload;
          shadow_rows.insert(pos, row);
          push_result(STAT_OK, '0, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        pos = n;
        for (int i = 0; i < n && pos == n; i++) begin
          if (shadow_rows[i].key == c.key) pos = i;
        end
        if (pos == n) begin
          push_result(STAT_NOTFOUND, '0, '0, 1'b1);
        end else begin
          shadow_rows.delete(pos);
          push_result(STAT_OK, '0, '0, 1'b1);
        end
      end
      CMD_CLEAR: begin
        shadow_rows.delete();
        push_result(STAT_OK, '0, '0, 1'b1);
      end
      default: begin
        if (n == 0) begin
          push_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            push_result(STAT_OK, shadow_rows[i].key, shadow_rows[i].payload, i == n - 1);
          end
        end
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 32'(int'($urandom_range(0, 16)) - 8);
    if (sel < 8) begin
      case ($urandom_range(0, 5))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h8000_0001;
        3: return 32'h7fff_fffe;
        4: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [63:0] rand_payload();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic cmd_e pick_cmd(int ins, int del, int rd);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins) return CMD_INSERT;
    if (r < ins + del) return CMD_DELETE;
    if (r < ins + del + rd) return CMD_READ;
    return CMD_CLEAR;
  endfunction

  function automatic void push_cmd(cmd_e cmd, logic [31:0] key, logic [63:0] payload,
                                   bit drain);
    table_cmd_t c;
    c.cmd     = cmd;
    c.key     = key;
    c.payload = payload;
    c.drain   = drain;
    cmd_q.push_back(c);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_table_cmd(cur_cmd);
        presenting = 1'b0;
        if (!tail_phase && $urandom_range(0, 99) < 25) in_gap = $urandom_range(1, 10);
      end
      if (!presenting) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && due_results.size() != 0)) begin
          cur_cmd = cmd_q.pop_front();
          presenting = 1'b1;
          s_axis_tdata <= {cur_cmd.payload, cur_cmd.key};
          s_axis_tuser <= cur_cmd.cmd;
        end
      end
      s_axis_tvalid <= presenting;
      tail_phase <= (cmd_q.size() <= QuietItems);
    end
  end

  always @(posedge clk_i) begin
    table_result_t want;
    bit            rdy;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected item", 64'(m_axis_tdata[95:0]), '0);
        end else begin
          want = due_results.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
          if (m_axis_tdata[31:0] != want.key)
            report_mismatch("out_key", 64'(m_axis_tdata[31:0]), 64'(want.key));
          if (m_axis_tdata[95:32] != want.payload)
            report_mismatch("out_payload", m_axis_tdata[95:32], want.payload);
          if (m_axis_tdata[101:96] != want.fill)
            report_mismatch("entry_count", 64'(m_axis_tdata[101:96]), 64'(want.fill));
          if (m_axis_tdata[103:102] != 2'b00)
            report_mismatch("padding", 64'(m_axis_tdata[103:102]), '0);
          if (m_axis_tlast != want.is_last)
            report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.is_last));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!tail_phase && $urandom_range(0, 99) < 8) out_stall = $urandom_range(1, 10);
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("sorted_key_table_top_tb failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int   n_random;
    int   seg_len;
    int   mode;
    bit   drain;
    cmd_e c;

    rst_ni <= 1'b0;

    push_cmd(CMD_READ, rand_key(), rand_payload(), 1'b0);
    push_cmd(CMD_DELETE, 32'd5, rand_payload(), 1'b0);
    push_cmd(CMD_INSERT, 32'd0, 64'h0, 1'b0);
    push_cmd(CMD_INSERT, 32'd0, 64'hffff_ffff_ffff_ffff, 1'b0);
    push_cmd(CMD_INSERT, 32'h7fff_ffff, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    push_cmd(CMD_INSERT, 32'h8000_0000, 64'h5555_5555_5555_5555, 1'b0);
    push_cmd(CMD_INSERT, 32'hffff_ffff, rand_payload(), 1'b0);
    push_cmd(CMD_INSERT, 32'd7, rand_payload(), 1'b0);
    push_cmd(CMD_INSERT, 32'd7, rand_payload(), 1'b0);
    push_cmd(CMD_READ, rand_key(), rand_payload(), 1'b0);
    push_cmd(CMD_DELETE, 32'd7, rand_payload(), 1'b0);
    push_cmd(CMD_DELETE, 32'd1234, rand_payload(), 1'b0);
    push_cmd(CMD_DELETE, 32'h8000_0000, rand_payload(), 1'b0);
    push_cmd(CMD_DELETE, 32'h7fff_ffff, rand_payload(), 1'b0);
    push_cmd(CMD_READ, rand_key(), rand_payload(), 1'b0);
    push_cmd(CMD_CLEAR, rand_key(), rand_payload(), 1'b0);
    push_cmd(CMD_READ, rand_key(), rand_payload(), 1'b0);
    push_cmd(CMD_DELETE, 32'd0, rand_payload(), 1'b0);
    push_cmd(CMD_INSERT, 32'd3, rand_payload(), 1'b0);
    push_cmd(CMD_INSERT, 32'd1, rand_payload(), 1'b0);
    push_cmd(CMD_INSERT, 32'd2, rand_payload(), 1'b0);
    push_cmd(CMD_READ, rand_key(), rand_payload(), 1'b1);
    push_cmd(CMD_CLEAR, rand_key(), rand_payload(), 1'b0);

    // fill past capacity, then read the full table
    for (int i = 0; i < Depth + 2; i++) push_cmd(CMD_INSERT, rand_key(), rand_payload(), 1'b0);
    push_cmd(CMD_READ, rand_key(), rand_payload(), 1'b1);
    n_random = cmd_q.size();

    while (n_random < RandomItems) begin
      mode    = $urandom_range(0, 3);
      seg_len = (mode == 0) ? $urandom_range(20, 40) :
                (mode == 3) ? $urandom_range(3, 8) : $urandom_range(8, 20);
      drain   = ($urandom_range(0, 99) < 25);
      for (int i = 0; i < seg_len; i++) begin
        case (mode)
          0:       c = pick_cmd(85, 8, 7);
          3:       c = cmd_e'($urandom_range(0, 3));
          default: c = pick_cmd(40, 35, 20);
        endcase
        push_cmd(c, (mode == 3) ? 32'($urandom) : rand_key(), rand_payload(),
                 drain && i == 0);
      end
      n_random += seg_len;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || presenting || due_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("sorted_key_table_top_tb passed");
    end else begin
      $display("sorted_key_table_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== sorted_key_table_top.f =====
+incdir+rtl/core
rtl/core/skt_pkg.sv
rtl/core/sorted_key_table_top.sv
tb/sorted_key_table_top_tb.sv
